// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cursor engine
// Field widths, request and key codes, datapath command/status structs.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 4;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [REQ_W-1:0] REQ_CHAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] KEY_UP    = 8'h91;
  localparam logic [CHAR_W-1:0] KEY_DOWN  = 8'h92;
  localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h93;
  localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h94;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // memory operations
  localparam int MEM_OP_W = 3;
  localparam logic [MEM_OP_W-1:0] MEM_NONE     = 3'd0;
  localparam logic [MEM_OP_W-1:0] MEM_RD_REQ   = 3'd1;
  localparam logic [MEM_OP_W-1:0] MEM_RD_BELOW = 3'd2;
  localparam logic [MEM_OP_W-1:0] MEM_RD_RIGHT = 3'd3;
  localparam logic [MEM_OP_W-1:0] MEM_WR_CHAR  = 3'd4;
  localparam logic [MEM_OP_W-1:0] MEM_WR_BLANK = 3'd5;
  localparam logic [MEM_OP_W-1:0] MEM_WR_INIT  = 3'd6;
  localparam logic [MEM_OP_W-1:0] MEM_WR_RDATA = 3'd7;

  // sweep pointer operations
  localparam int PTR_OP_W = 2;
  localparam logic [PTR_OP_W-1:0] PTR_HOLD   = 2'd0;
  localparam logic [PTR_OP_W-1:0] PTR_ZERO   = 2'd1;
  localparam logic [PTR_OP_W-1:0] PTR_CURSOR = 2'd2;
  localparam logic [PTR_OP_W-1:0] PTR_INC    = 2'd3;

  typedef struct packed {
    logic                capture;
    logic                cur_char;
    logic                cur_left;
    logic                cur_home;
    logic [PTR_OP_W-1:0] ptr_op;
    logic [MEM_OP_W-1:0] mem_op;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             is_bs;
    logic             is_print;
    logic             at_home;
    logic             scroll;
    logic             ptr_col_last;
    logic             ptr_row_last;
    logic             ptr_row_penult;
    logic             rdata_space;
    logic             out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcce_ctrl: sequencer of the text console cursor engine
// Steps the datapath through clear sweeps, scrolls, backspace shifts and reads.
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  tcce_pkg::dp_stat_t stat,
  output tcce_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_RD_WAIT  = 4'd3;
  localparam logic [3:0] S_CLR      = 4'd4;
  localparam logic [3:0] S_SC_RD    = 4'd5;
  localparam logic [3:0] S_SC_WR    = 4'd6;
  localparam logic [3:0] S_SC_BLANK = 4'd7;
  localparam logic [3:0] S_BS_LEFT  = 4'd8;
  localparam logic [3:0] S_BS_PTR   = 4'd9;
  localparam logic [3:0] S_BS_CHK   = 4'd10;
  localparam logic [3:0] S_BS_WR    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.mem_op = tcce_pkg::MEM_WR_INIT;
        if (stat.ptr_row_last && stat.ptr_col_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.ptr_op = tcce_pkg::PTR_INC;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req)
          tcce_pkg::REQ_CHAR: begin
            if (stat.is_bs) begin
              state_next = stat.at_home ? S_DONE : S_BS_LEFT;
            end else begin
              cmd.cur_char = 1'b1;
              if (stat.is_print) begin
                cmd.mem_op = tcce_pkg::MEM_WR_CHAR;
              end
              if (stat.scroll) begin
                cmd.ptr_op = tcce_pkg::PTR_ZERO;
                state_next = S_SC_RD;
              end else begin
                state_next = S_DONE;
              end
            end
          end
          tcce_pkg::REQ_CLEAR: begin
            cmd.cur_home = 1'b1;
            cmd.ptr_op   = tcce_pkg::PTR_ZERO;
            state_next   = S_CLR;
          end
          tcce_pkg::REQ_READ: begin
            cmd.mem_op = tcce_pkg::MEM_RD_REQ;
            state_next = S_RD_WAIT;
          end
          tcce_pkg::REQ_NOP: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RD_WAIT: begin
        state_next = S_DONE;
      end
      S_CLR: begin
        cmd.mem_op = tcce_pkg::MEM_WR_BLANK;
        if (stat.ptr_row_last && stat.ptr_col_last) begin
          state_next = S_DONE;
        end else begin
          cmd.ptr_op = tcce_pkg::PTR_INC;
        end
      end
      S_SC_RD: begin
        cmd.mem_op = tcce_pkg::MEM_RD_BELOW;
        state_next = S_SC_WR;
      end
      S_SC_WR: begin
        // incrementing past the end of the next-to-last row lands on the last row
        cmd.mem_op = tcce_pkg::MEM_WR_RDATA;
        cmd.ptr_op = tcce_pkg::PTR_INC;
        state_next = (stat.ptr_row_penult && stat.ptr_col_last) ? S_SC_BLANK : S_SC_RD;
      end
      S_SC_BLANK: begin
        cmd.mem_op = tcce_pkg::MEM_WR_BLANK;
        if (stat.ptr_col_last) begin
          state_next = S_DONE;
        end else begin
          cmd.ptr_op = tcce_pkg::PTR_INC;
        end
      end
      S_BS_LEFT: begin
        cmd.cur_left = 1'b1;
        state_next   = S_BS_PTR;
      end
      S_BS_PTR: begin
        cmd.ptr_op = tcce_pkg::PTR_CURSOR;
        state_next = S_BS_CHK;
      end
      S_BS_CHK: begin
        if (stat.ptr_col_last) begin
          cmd.mem_op = tcce_pkg::MEM_WR_BLANK;
          state_next = S_DONE;
        end else begin
          cmd.mem_op = tcce_pkg::MEM_RD_RIGHT;
          state_next = S_BS_WR;
        end
      end
      S_BS_WR: begin
        if (stat.rdata_space) begin
          cmd.mem_op = tcce_pkg::MEM_WR_BLANK;
          state_next = S_DONE;
        end else begin
          cmd.mem_op = tcce_pkg::MEM_WR_RDATA;
          cmd.ptr_op = tcce_pkg::PTR_INC;
          state_next = S_BS_CHK;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tcce_dp.sv =====
// ----------------------------------------------------------------------------
// tcce_dp: datapath of the text console cursor engine
// Screen memory, cursor, sweep pointer, request capture and result register.
// ----------------------------------------------------------------------------
module tcce_dp #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STEP = tcce_pkg::TAB_STEP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcce_pkg::dp_cmd_t             cmd,
  output tcce_pkg::dp_stat_t            stat,
  input  logic [tcce_pkg::REQ_W-1:0]    req_type,
  input  logic [tcce_pkg::CHAR_W-1:0]   char_byte,
  input  logic [tcce_pkg::ROW_W-1:0]    read_row,
  input  logic [tcce_pkg::COL_W-1:0]    read_col,
  input  logic [tcce_pkg::ATTR_W-1:0]   text_attribute,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [tcce_pkg::POS_W-1:0]    cursor_pos,
  output logic [tcce_pkg::CELL_W-1:0]   cell_value
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;

  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [RW-1:0] ROW_PEN  = RW'(ROWS - 2);

  logic [tcce_pkg::CELL_W-1:0] mem [0:DEPTH-1];

  logic [tcce_pkg::REQ_W-1:0]  req_q;
  logic [tcce_pkg::CHAR_W-1:0] ch_q;
  logic [tcce_pkg::ROW_W-1:0]  rr_q;
  logic [tcce_pkg::COL_W-1:0]  rc_q;
  logic [RW-1:0]               cur_row;
  logic [CW-1:0]               cur_col;
  logic [RW-1:0]               cur_row_next;
  logic [CW-1:0]               cur_col_next;
  logic [RW-1:0]               ptr_row;
  logic [CW-1:0]               ptr_col;
  logic [tcce_pkg::CELL_W-1:0] rdata;

  // cursor candidates
  logic [RW-1:0] left_row;
  logic [CW-1:0] left_col;
  logic [RW-1:0] chr_row;
  logic [CW-1:0] chr_col;
  logic          row_inc;
  logic          scroll;
  logic          is_print;
  logic [CW:0]   tab_sum;
  logic          in_range;
  logic [AW-1:0] pos;

  // memory port controls
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [tcce_pkg::CELL_W-1:0] wdata;
  logic                        re;
  logic [AW-1:0]               raddr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      ch_q  <= char_byte;
      rr_q  <= read_row;
      rc_q  <= read_col;
    end
  end

  // step left, shared by the left key and backspace
  always_comb begin
    left_row = cur_row;
    left_col = cur_col;
    if (cur_col != '0) begin
      left_col = cur_col - CW'(1);
    end else if (cur_row != '0) begin
      left_row = cur_row - RW'(1);
      left_col = COL_LAST;
    end
  end

  assign tab_sum = {1'b0, cur_col} + (CW+1)'(TAB_STEP);

  always_comb begin
    chr_row = cur_row;
    chr_col = cur_col;
    row_inc = 1'b0;
    case (ch_q)
      tcce_pkg::KEY_LEFT: begin
        chr_row = left_row;
        chr_col = left_col;
      end
      tcce_pkg::KEY_RIGHT: begin
        if (cur_col < COL_LAST) begin
          chr_col = cur_col + CW'(1);
        end else begin
          chr_col = '0;
          row_inc = 1'b1;
        end
      end
      tcce_pkg::KEY_UP: begin
        if (cur_row != '0) begin
          chr_row = cur_row - RW'(1);
        end
      end
      tcce_pkg::KEY_DOWN: begin
        row_inc = 1'b1;
      end
      tcce_pkg::CH_LF: begin
        chr_col = '0;
        row_inc = 1'b1;
      end
      tcce_pkg::CH_CR: begin
        chr_col = '0;
      end
      tcce_pkg::CH_TAB: begin
        if (tab_sum >= (CW+1)'(COLUMNS)) begin
          chr_col = '0;
          row_inc = 1'b1;
        end else begin
          chr_col = tab_sum[CW-1:0];
        end
      end
      tcce_pkg::CH_BS: begin
        chr_col = cur_col;
      end
      default: begin
        if (cur_col == COL_LAST) begin
          chr_col = '0;
          row_inc = 1'b1;
        end else begin
          chr_col = cur_col + CW'(1);
        end
      end
    endcase
    // leaving the last row: cursor stays there and the screen scrolls
    scroll = row_inc && (cur_row == ROW_LAST);
    if (row_inc && !scroll) begin
      chr_row = cur_row + RW'(1);
    end
  end

  always_comb begin
    case (ch_q) inside
      tcce_pkg::CH_BS, tcce_pkg::CH_TAB, tcce_pkg::CH_LF, tcce_pkg::CH_CR,
      tcce_pkg::KEY_UP, tcce_pkg::KEY_DOWN, tcce_pkg::KEY_LEFT, tcce_pkg::KEY_RIGHT:
        is_print = 1'b0;
      default:
        is_print = 1'b1;
    endcase
  end

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    if (cmd.cur_home) begin
      cur_row_next = '0;
      cur_col_next = '0;
    end else if (cmd.cur_left) begin
      cur_row_next = left_row;
      cur_col_next = left_col;
    end else if (cmd.cur_char) begin
      cur_row_next = chr_row;
      cur_col_next = chr_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      ptr_row <= '0;
      ptr_col <= '0;
    end else begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      case (cmd.ptr_op)
        tcce_pkg::PTR_ZERO: begin
          ptr_row <= '0;
          ptr_col <= '0;
        end
        tcce_pkg::PTR_CURSOR: begin
          ptr_row <= cur_row;
          ptr_col <= cur_col;
        end
        tcce_pkg::PTR_INC: begin
          if (ptr_col == COL_LAST) begin
            ptr_col <= '0;
            ptr_row <= ptr_row + RW'(1);
          end else begin
            ptr_col <= ptr_col + CW'(1);
          end
        end
        default: begin
          ptr_col <= ptr_col;
        end
      endcase
    end
  end

  assign in_range = ({1'b0, rr_q} < (tcce_pkg::ROW_W+1)'(ROWS)) &&
                    ({1'b0, rc_q} < (tcce_pkg::COL_W+1)'(COLUMNS));

  always_comb begin
    we    = 1'b0;
    waddr = {ptr_row, ptr_col};
    wdata = rdata;
    re    = 1'b0;
    raddr = {ptr_row, ptr_col};
    case (cmd.mem_op)
      tcce_pkg::MEM_RD_REQ: begin
        re    = in_range;
        raddr = {rr_q[RW-1:0], rc_q[CW-1:0]};
      end
      tcce_pkg::MEM_RD_BELOW: begin
        re    = 1'b1;
        raddr = {ptr_row + RW'(1), ptr_col};
      end
      tcce_pkg::MEM_RD_RIGHT: begin
        re    = 1'b1;
        raddr = {ptr_row, ptr_col + CW'(1)};
      end
      tcce_pkg::MEM_WR_CHAR: begin
        we    = 1'b1;
        waddr = {cur_row, cur_col};
        wdata = {text_attribute, ch_q};
      end
      tcce_pkg::MEM_WR_BLANK: begin
        we    = 1'b1;
        wdata = {text_attribute, tcce_pkg::CH_SPACE};
      end
      tcce_pkg::MEM_WR_INIT: begin
        we    = 1'b1;
        wdata = tcce_pkg::RESET_CELL;
      end
      tcce_pkg::MEM_WR_RDATA: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign pos = AW'(cur_row) * AW'(COLUMNS) + AW'(cur_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_pos <= tcce_pkg::POS_W'(pos);
      cell_value <= (req_q == tcce_pkg::REQ_READ && in_range) ? rdata : '0;
    end
  end

  always_comb begin
    stat.req            = req_q;
    stat.is_bs          = (ch_q == tcce_pkg::CH_BS);
    stat.is_print       = is_print;
    stat.at_home        = (cur_row == '0) && (cur_col == '0);
    stat.scroll         = scroll;
    stat.ptr_col_last   = (ptr_col == COL_LAST);
    stat.ptr_row_last   = (ptr_row == ROW_LAST);
    stat.ptr_row_penult = (ptr_row == ROW_PEN);
    stat.rdata_space    = (rdata[tcce_pkg::CHAR_W-1:0] == tcce_pkg::CH_SPACE);
    stat.out_busy       = m_tvalid && !m_tready;
  end

endmodule

// ===== rtl/text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit: text console with cursor and screen memory
// Stream in typed bytes and commands, stream out cursor position and cell.
// ----------------------------------------------------------------------------
// Each request gives one result. After reset the screen memory is swept to
// blank grey-on-black, one cell after another, before the first request is
// taken; configuration writes are taken at any time. The screen memory is used
// for one read or one write at a time, which sets the long cases: a clear
// writes every cell in turn, a scroll moves the cells of the lower rows up
// (one read then one write per moved cell) and blanks the last row, and a
// backspace pulls the cells right of the cursor left until a space or the row
// end (nothing moves at home). The result register lets the next request enter
// while the previous result waits.
module text_console_cursor_engine_unit #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STEP = tcce_pkg::TAB_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_byte[7:0], read_row[12:8], read_col[19:13], zero
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_pos[10:0], cell_value[26:11], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcce_pkg::dp_cmd_t  cmd;
  tcce_pkg::dp_stat_t stat;

  logic [tcce_pkg::ATTR_W-1:0] text_attribute;
  logic [tcce_pkg::POS_W-1:0]  cursor_pos;
  logic [tcce_pkg::CELL_W-1:0] cell_value;

  assign pready = 1'b1;

  // one register; word index is paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcce_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      text_attribute <= pwdata[tcce_pkg::ATTR_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {24'd0, text_attribute};

  assign m_tdata = {5'd0, cell_value, cursor_pos};

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcce_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (s_tuser),
    .char_byte      (s_tdata[7:0]),
    .read_row       (s_tdata[12:8]),
    .read_col       (s_tdata[19:13]),
    .text_attribute (text_attribute),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .cursor_pos     (cursor_pos),
    .cell_value     (cell_value)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of text_console_cursor_engine_unit
// Drives typed bytes, cursor keys, clears, no-ops and cell reads into the stream
// and checks every cursor/cell report against a bench screen model or, for known
// directed entries, their listed values. A directed list comes first, then random
// bursts of typing, editing, scrolling and reads under several text attributes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int COLS           = tcce_pkg::COLUMNS_DEF;
  localparam int LINES          = tcce_pkg::ROWS_DEF;
  localparam int TAB            = tcce_pkg::TAB_STEP_DEF;
  localparam int CELLS          = COLS * LINES;
  localparam int IDLE_PCT       = 7;
  localparam int STALL_LIMIT    = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT        = 120;
  localparam int CALM_LO        = 160;
  localparam int CALM_HI        = 230;
  localparam int RAND_PER_PHASE = 75;
  localparam int TAIL_CYCLES    = 50;

  localparam logic [2:0] ADDR_TEXT_ATTR = 3'd0;

  typedef struct packed {
    logic [tcce_pkg::POS_W-1:0]  pos;
    logic [tcce_pkg::CELL_W-1:0] cell_val;
  } cursor_report_t;

  typedef struct {
    logic [tcce_pkg::REQ_W-1:0]  req;
    logic [tcce_pkg::CHAR_W-1:0] ch;
    logic [tcce_pkg::ROW_W-1:0]  rr;
    logic [tcce_pkg::COL_W-1:0]  rc;
    bit                          known;
    logic [tcce_pkg::POS_W-1:0]  pos;
    logic [tcce_pkg::CELL_W-1:0] cell_val;
  } plan_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;  // char_byte[7:0], read_row[12:8], read_col[19:13], zero
  logic [1:0]  s_tuser  = '0;  // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // cursor_pos[10:0], cell_value[26:11], zero
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_cursor_engine_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // screen model
  logic [tcce_pkg::CELL_W-1:0] screen_img [CELLS];
  int                          cur_row;
  int                          cur_col;
  logic [tcce_pkg::ATTR_W-1:0] attr_img;

  cursor_report_t cursor_reports [$];
  int             mismatches   = 0;
  int             sent         = 0;
  int             results_seen = 0;

  function automatic void flag(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %h, got %h", what, want, got);
  endfunction

  function automatic void step_back();
    if (cur_col > 0) begin
      cur_col--;
    end else if (cur_row > 0) begin
      cur_row--;
      cur_col = COLS - 1;
    end
  endfunction

  function automatic void type_byte(logic [tcce_pkg::CHAR_W-1:0] ch);
    int p;
    int row_end;
    case (ch)
      tcce_pkg::CH_BS: begin
        if (cur_row != 0 || cur_col != 0) begin
          step_back();
          p       = cur_row * COLS + cur_col;
          row_end = cur_row * COLS + COLS - 1;
          // pull the rest of the row left until a space
          while (p < row_end && screen_img[p + 1][7:0] != tcce_pkg::CH_SPACE) begin
            screen_img[p] = screen_img[p + 1];
            p++;
          end
          screen_img[p] = {attr_img, tcce_pkg::CH_SPACE};
        end
      end
      tcce_pkg::KEY_LEFT:  step_back();
      tcce_pkg::KEY_UP:    if (cur_row > 0) cur_row--;
      tcce_pkg::KEY_DOWN:  cur_row++;
      tcce_pkg::KEY_RIGHT: begin
        if (cur_col < COLS - 1) begin
          cur_col++;
        end else begin
          cur_col = 0;
          cur_row++;
        end
      end
      tcce_pkg::CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      tcce_pkg::CH_CR: cur_col = 0;
      tcce_pkg::CH_TAB: begin
        cur_col += TAB;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      default: begin
        screen_img[cur_row * COLS + cur_col] = {attr_img, ch};
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
      end
    endcase
    // only downward moves can get here with the row past the bottom
    if (cur_row >= LINES) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_img[i] = screen_img[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++)
        screen_img[i] = {attr_img, tcce_pkg::CH_SPACE};
      cur_row = LINES - 1;
    end
  endfunction

  function automatic cursor_report_t console_apply(logic [tcce_pkg::REQ_W-1:0] req,
                                                   logic [tcce_pkg::CHAR_W-1:0] ch,
                                                   logic [tcce_pkg::ROW_W-1:0] rr,
                                                   logic [tcce_pkg::COL_W-1:0] rc);
    cursor_report_t r;
    r.cell_val = '0;
    case (req)
      tcce_pkg::REQ_CHAR: type_byte(ch);
      tcce_pkg::REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_img[i] = {attr_img, tcce_pkg::CH_SPACE};
        cur_row = 0;
        cur_col = 0;
      end
      tcce_pkg::REQ_READ: begin
        if (int'(rr) < LINES && int'(rc) < COLS) r.cell_val = screen_img[rr * COLS + rc];
      end
      default: ;
    endcase
    r.pos = tcce_pkg::POS_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  task automatic issue(input logic [tcce_pkg::REQ_W-1:0] req,
                       input logic [tcce_pkg::CHAR_W-1:0] ch,
                       input logic [tcce_pkg::ROW_W-1:0] rr,
                       input logic [tcce_pkg::COL_W-1:0] rc,
                       input bit known = 1'b0,
                       input logic [tcce_pkg::POS_W-1:0] pos = '0,
                       input logic [tcce_pkg::CELL_W-1:0] cell_val = '0);
    cursor_report_t want;
    @(negedge clk);
    while (!(sent >= CALM_LO && sent < CALM_HI) && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, rc, rr, ch};
    do @(posedge clk); while (!s_tready);
    want = console_apply(req, ch, rr, rc);
    if (known) begin
      want.pos      = pos;
      want.cell_val = cell_val;
    end
    cursor_reports.push_back(want);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_attr(input logic [tcce_pkg::ATTR_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TEXT_ATTR;
    pwdata  <= {24'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    attr_img = v;
    // read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'b0, v}) flag("text_attribute readback", v, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off, and a calm stretch
  int hold_left = 0;
  bit held      = 1'b0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (results_seen >= HOLD_AT && !held) begin
      held      = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                  ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : report_check
    cursor_report_t head;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (cursor_reports.size() == 0) begin
        flag("report with no request pending", 0, m_tdata);
      end else begin
        head = cursor_reports.pop_front();
        if (m_tdata[10:0] !== head.pos) flag("cursor_pos", head.pos, m_tdata[10:0]);
        if (m_tdata[26:11] !== head.cell_val)
          flag("cell_value", head.cell_val, m_tdata[26:11]);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  plan_row_t plan [27] = '{
    '{tcce_pkg::REQ_READ,  8'h00,               5'd0,  7'd0,   1'b1, 11'd0, 16'h0720},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd24, 7'd79,  1'b1, 11'd0, 16'h0720},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd25, 7'd0,   1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd0,  7'd80,  1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_NOP,   8'hFF,               5'd31, 7'd127, 1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::CH_BS,     5'd0,  7'd0,   1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_LEFT,  5'd0,  7'd0,   1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_UP,    5'd0,  7'd0,   1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  8'h41,               5'd0,  7'd0,   1'b1, 11'd1, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  8'hFF,               5'd0,  7'd0,   1'b1, 11'd2, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  8'h80,               5'd0,  7'd0,   1'b1, 11'd3, 16'h0000},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd0,  7'd1,   1'b1, 11'd3, 16'h07FF},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::CH_TAB,    5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::CH_CR,     5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_RIGHT, 5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_DOWN,  5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::CH_LF,     5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::CH_BS,     5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  8'h00,               5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_UP,    5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_UP,    5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::KEY_RIGHT, 5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CHAR,  tcce_pkg::CH_BS,     5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd0,  7'd0,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd0,  7'd2,   1'b0, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_CLEAR, 8'h00,               5'd0,  7'd0,   1'b1, 11'd0, 16'h0000},
    '{tcce_pkg::REQ_READ,  8'h00,               5'd0,  7'd0,   1'b1, 11'd0, 16'h0720}
  };

  logic [tcce_pkg::CHAR_W-1:0] moves [3] =
    '{tcce_pkg::KEY_LEFT, tcce_pkg::KEY_UP, tcce_pkg::KEY_RIGHT};
  logic [tcce_pkg::CHAR_W-1:0] line_ops [3] =
    '{tcce_pkg::CH_LF, tcce_pkg::CH_CR, tcce_pkg::CH_TAB};

  initial begin
    int                          mode;
    int                          target;
    logic [tcce_pkg::CHAR_W-1:0] g;
    logic [tcce_pkg::ATTR_W-1:0] attr_pick;

    for (int i = 0; i < CELLS; i++) screen_img[i] = tcce_pkg::RESET_CELL;
    cur_row  = 0;
    cur_col  = 0;
    attr_img = tcce_pkg::ATTR_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      issue(plan[i].req, plan[i].ch, plan[i].rr, plan[i].rc,
            plan[i].known, plan[i].pos, plan[i].cell_val);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      attr_pick = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF :
                  tcce_pkg::ATTR_W'($urandom_range(0, 255));
      write_attr(attr_pick);
      target = sent + RAND_PER_PHASE;
      while (sent < target) begin
        mode = $urandom_range(0, 99);
        if (mode < 30) begin
          // a word of printable bytes, sometimes broken by spaces
          repeat ($urandom_range(1, 12)) begin
            g = tcce_pkg::CHAR_W'($urandom_range(0, 255));
            while (g inside {tcce_pkg::CH_BS, tcce_pkg::CH_TAB, tcce_pkg::CH_LF,
                             tcce_pkg::CH_CR, tcce_pkg::KEY_UP, tcce_pkg::KEY_DOWN,
                             tcce_pkg::KEY_LEFT, tcce_pkg::KEY_RIGHT})
              g = tcce_pkg::CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) g = tcce_pkg::CH_SPACE;
            issue(tcce_pkg::REQ_CHAR, g, tcce_pkg::ROW_W'($urandom_range(0, 31)),
                  tcce_pkg::COL_W'($urandom_range(0, 127)));
          end
        end else if (mode < 42) begin
          repeat ($urandom_range(1, 3))
            issue(tcce_pkg::REQ_CHAR, line_ops[$urandom_range(0, 2)], '0, '0);
        end else if (mode < 52) begin
          // head for the bottom row so that scrolls happen
          repeat ($urandom_range(2, 12))
            issue(tcce_pkg::REQ_CHAR,
                  $urandom_range(0, 1) ? tcce_pkg::KEY_DOWN : tcce_pkg::CH_LF, '0, '0);
        end else if (mode < 67) begin
          repeat ($urandom_range(1, 4))
            issue(tcce_pkg::REQ_CHAR, moves[$urandom_range(0, 2)], '0, '0);
          repeat ($urandom_range(1, 4)) issue(tcce_pkg::REQ_CHAR, tcce_pkg::CH_BS, '0, '0);
        end else if (mode < 82) begin
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1))
              issue(tcce_pkg::REQ_READ, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    tcce_pkg::ROW_W'(cur_row > 0 ? cur_row - $urandom_range(0, 1) : 0),
                    tcce_pkg::COL_W'($urandom_range(0, COLS - 1)));
            else
              issue(tcce_pkg::REQ_READ, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    tcce_pkg::ROW_W'($urandom_range(0, 31)),
                    tcce_pkg::COL_W'($urandom_range(0, 127)));
          end
        end else if (mode < 90) begin
          issue(tcce_pkg::REQ_W'($urandom_range(0, 3)),
                tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                tcce_pkg::ROW_W'($urandom_range(0, 31)),
                tcce_pkg::COL_W'($urandom_range(0, 127)));
        end else if (mode < 93) begin
          issue(tcce_pkg::REQ_CLEAR, tcce_pkg::CHAR_W'($urandom_range(0, 255)), '0, '0);
        end else begin
          // tab runs cross the row end
          repeat ($urandom_range(1, 22)) issue(tcce_pkg::REQ_CHAR, tcce_pkg::CH_TAB, '0, '0);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
